// File: design/assert_macros.svh
// assertion macros shared by the text terminal rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock, disabled while the active-low reset is low
`define TTCW_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent check on the usual clock and reset names
`define TTCW_ASSERT(lbl, prop, msg) \
  `TTCW_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/ttcw_pkg.sv
// shared types and constants of the text terminal character writer
// no dependencies; used by every module of the block
`default_nettype none

package ttcw_pkg;

  // screen store geometry
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 32;
  localparam int COL_W    = 6;
  localparam int ROW_W    = 5;
  localparam int ADDR_W   = ROW_W + COL_W;

  // configuration register widths and reset values
  localparam int COLS_CFG_W = 7;
  localparam int ROWS_CFG_W = 6;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd64;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [COLS_CFG_W-1:0] COLS_MAX   = 7'd64;
  localparam logic [ROWS_CFG_W-1:0] ROWS_MAX   = 6'd32;

  // character codes
  localparam logic [7:0] BLANK           = 8'h20;
  localparam logic [7:0] NEWLINE         = 8'h0a;
  localparam logic [7:0] FIRST_PRINTABLE = 8'h20;

  // input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_HOME  = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // register select, taken from address bit 2
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // bus widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_NEWLINE,
    CMD_IGNORE,
    CMD_CLEAR,
    CMD_HOME,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] rd_addr;
  } cmd_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [7:0]       read_data;
    logic [5:0]       cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             new_line;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic             wrote_char;
    logic             scrolled;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// File: design/text_terminal_char_writer_top.sv
// top level of the text terminal character writer: ports, config registers, checks
// depends on ttcw_pkg, ttcw_front, ttcw_queue, ttcw_back and assert_macros.svh
`default_nettype none

// Character-cell terminal on a 2048 x 8 screen store (32 rows by 64 columns,
// the region in use set by the column and row registers). After reset the
// store is swept to spaces, one cell a cycle; no item is taken during that
// time, though the registers may be written. Items queue in a two-entry
// buffer and the back end works on one at a time. Write-char, newline,
// control bytes and home are done from the idle state; a cell read waits on
// the registered read port of the store. A clear sweeps all 2048 cells. An
// item that scrolls copies the region through the single store port pair,
// one cell a cycle. The result register holds one result; while it waits
// unaccepted the back end holds off the next item, and the queue keeps
// taking input until both entries are filled.
module text_terminal_char_writer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[18:13], zero fill above
  input  logic [ttcw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mode[1:0]
  input  logic [ttcw_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // scrolled[0], wrote_char[1], cell_row[6:2], cell_col[12:7], new_line[13],
  // cursor_col[19:14], cursor_row[25:20], read_data[33:26], zero fill above
  output logic [ttcw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ttcw_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ttcw_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ttcw_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

`include "assert_macros.svh"

  logic [ttcw_pkg::COLS_CFG_W-1:0] cfg_cols_q, cfg_cols_d;
  logic [ttcw_pkg::ROWS_CFG_W-1:0] cfg_rows_q, cfg_rows_d;
  logic                            cfg_write;

  ttcw_pkg::cmd_t                  front_cmd;
  ttcw_pkg::cmd_t                  q_cmd;
  logic                            q_push;
  logic                            q_full;
  logic                            q_pop;
  logic                            q_empty;
  logic                            init_done;
  ttcw_pkg::result_t               res;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_comb begin
    cfg_cols_d = cfg_cols_q;
    cfg_rows_d = cfg_rows_q;
    prdata     = '0;
    unique case (paddr[2])
      ttcw_pkg::REG_COLS: begin
        prdata = ttcw_pkg::APB_DATA_W'(cfg_cols_q);
        if (cfg_write) begin
          cfg_cols_d = pwdata[ttcw_pkg::COLS_CFG_W-1:0];
        end
      end
      ttcw_pkg::REG_ROWS: begin
        prdata = ttcw_pkg::APB_DATA_W'(cfg_rows_q);
        if (cfg_write) begin
          cfg_rows_d = pwdata[ttcw_pkg::ROWS_CFG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= ttcw_pkg::COLS_RESET;
      cfg_rows_q <= ttcw_pkg::ROWS_RESET;
    end else begin
      cfg_cols_q <= cfg_cols_d;
      cfg_rows_q <= cfg_rows_d;
    end
  end

  // front end
  ttcw_front u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .enable_i   (init_done),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  // command queue
  ttcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  // back end
  ttcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (q_cmd),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .cfg_cols_i  (cfg_cols_q),
    .cfg_rows_i  (cfg_rows_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .result_o    (res),
    .init_done_o (init_done)
  );

  // result packing
  assign m_axis_tdata = {{(ttcw_pkg::OUT_TDATA_W - ttcw_pkg::RES_W){1'b0}}, res};

  // checks
  `TTCW_ASSERT(a_no_accept_in_init, !init_done |-> !s_axis_tready, "item taken during reset sweep")
  `TTCW_ASSERT(a_pop_not_empty, q_pop |-> !q_empty, "command popped from empty queue")
  `TTCW_ASSERT(a_scroll_cause, m_axis_tvalid && res.scrolled |-> res.wrote_char || res.new_line, "scroll without char or newline")
  `TTCW_ASSERT(a_read_alone, m_axis_tvalid && (res.read_data != 8'd0) |-> !res.wrote_char && !res.new_line && !res.scrolled, "read data on a write result")

endmodule

`default_nettype wire

// File: design/ttcw_front.sv
// front end: unpacks input transactions and classifies them into commands
// depends on ttcw_pkg
`default_nettype none

module ttcw_front (
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [ttcw_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  logic [ttcw_pkg::IN_TUSER_W-1:0] s_tuser_i,
  input  logic                            enable_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output ttcw_pkg::cmd_t                  cmd_o
);

  logic [7:0]                 char_code;
  logic [ttcw_pkg::ROW_W-1:0] read_row;
  logic [ttcw_pkg::COL_W-1:0] read_col;

  // field unpacking
  assign char_code = s_tdata_i[7:0];
  assign read_row  = s_tdata_i[12:8];
  assign read_col  = s_tdata_i[18:13];

  // handshake towards the queue
  assign s_tready_o = enable_i & ~q_full_i;
  assign push_o     = s_tvalid_i & s_tready_o;

  // classification
  always_comb begin
    cmd_o         = '0;
    cmd_o.ch      = char_code;
    cmd_o.rd_addr = {read_row, read_col};
    unique case (s_tuser_i)
      ttcw_pkg::MODE_WRITE: begin
        if (char_code == ttcw_pkg::NEWLINE) begin
          cmd_o.kind = ttcw_pkg::CMD_NEWLINE;
        end else if (char_code >= ttcw_pkg::FIRST_PRINTABLE) begin
          cmd_o.kind = ttcw_pkg::CMD_CHAR;
        end else begin
          cmd_o.kind = ttcw_pkg::CMD_IGNORE;
        end
      end
      ttcw_pkg::MODE_CLEAR: cmd_o.kind = ttcw_pkg::CMD_CLEAR;
      ttcw_pkg::MODE_HOME:  cmd_o.kind = ttcw_pkg::CMD_HOME;
      ttcw_pkg::MODE_READ:  cmd_o.kind = ttcw_pkg::CMD_READ;
      default:              cmd_o.kind = ttcw_pkg::CMD_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/ttcw_queue.sv
// short command queue between the front and back ends
// depends on ttcw_pkg
`default_nettype none

module ttcw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttcw_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output ttcw_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  ttcw_pkg::cmd_t                entries_q [ttcw_pkg::QUEUE_DEPTH];
  logic [ttcw_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ttcw_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ttcw_pkg::QCNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == ttcw_pkg::QCNT_W'(ttcw_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ttcw_pkg::QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ttcw_pkg::QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   count_d = ttcw_pkg::QCNT_W'(count_q + 1'b1);
      2'b01:   count_d = ttcw_pkg::QCNT_W'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: design/ttcw_back.sv
// back end: cursor, screen store, scroll and clear sweeps, result register
// depends on ttcw_pkg
`default_nettype none

module ttcw_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ttcw_pkg::cmd_t                       cmd_i,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  input  logic [ttcw_pkg::COLS_CFG_W-1:0]      cfg_cols_i,
  input  logic [ttcw_pkg::ROWS_CFG_W-1:0]      cfg_rows_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output ttcw_pkg::result_t                    result_o,
  output logic                                 init_done_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK,
    ST_FINISH,
    ST_READ
  } state_e;

  state_e                               state_q, state_d;
  logic [ttcw_pkg::COL_W-1:0]           cur_col_q, cur_col_d;
  logic [5:0]                           cur_row_q, cur_row_d;
  ttcw_pkg::cmd_t                       cmd_q, cmd_d;
  logic [ttcw_pkg::ADDR_W-1:0]          sweep_q, sweep_d;
  logic [ttcw_pkg::ROW_W-1:0]           scr_row_q, scr_row_d;
  logic [ttcw_pkg::COL_W-1:0]           scr_col_q, scr_col_d;
  logic                                 wr_pend_q, wr_pend_d;
  logic [ttcw_pkg::ADDR_W-1:0]          wr_addr_q, wr_addr_d;
  logic                                 out_valid_q, out_valid_d;
  ttcw_pkg::result_t                    out_q, out_d;

  // screen store
  logic [7:0]                           mem_q [2**ttcw_pkg::ADDR_W];
  logic [7:0]                           rdata_q;
  logic                                 mem_we;
  logic [ttcw_pkg::ADDR_W-1:0]          mem_waddr;
  logic [7:0]                           mem_wdata;
  logic [ttcw_pkg::ADDR_W-1:0]          mem_raddr;

  // effective geometry
  logic [ttcw_pkg::COLS_CFG_W-1:0]      cols_eff;
  logic [ttcw_pkg::ROWS_CFG_W-1:0]      rows_eff;
  logic [ttcw_pkg::COL_W-1:0]           last_col;
  logic [ttcw_pkg::ROW_W-1:0]           last_row;
  logic                                 row_beyond;
  logic                                 out_free;

  // character placement
  logic [5:0]                           base_row;
  logic [ttcw_pkg::COL_W-1:0]           base_col;
  logic [ttcw_pkg::COL_W-1:0]           ch_col;
  logic [ttcw_pkg::COL_W:0]             ch_col_inc;
  logic                                 ch_wrap;
  logic [5:0]                           ch_next_row;
  logic [ttcw_pkg::COL_W-1:0]           ch_next_col;

  // register values out of range are clamped
  always_comb begin
    if (cfg_cols_i == '0) begin
      cols_eff = ttcw_pkg::COLS_CFG_W'(1);
    end else if (cfg_cols_i > ttcw_pkg::COLS_MAX) begin
      cols_eff = ttcw_pkg::COLS_MAX;
    end else begin
      cols_eff = cfg_cols_i;
    end
    if (cfg_rows_i == '0) begin
      rows_eff = ttcw_pkg::ROWS_CFG_W'(1);
    end else if (cfg_rows_i > ttcw_pkg::ROWS_MAX) begin
      rows_eff = ttcw_pkg::ROWS_MAX;
    end else begin
      rows_eff = cfg_rows_i;
    end
  end

  assign last_col   = ttcw_pkg::COL_W'(cols_eff - 1'b1);
  assign last_row   = ttcw_pkg::ROW_W'(rows_eff - 1'b1);
  assign row_beyond = (cur_row_q >= rows_eff);
  assign out_free   = ~out_valid_q | out_ready_i;

  // where a printable char lands and where the cursor goes next
  always_comb begin
    if (state_q == ST_FINISH) begin
      base_row = {1'b0, last_row};
      base_col = '0;
    end else begin
      base_row = cur_row_q;
      base_col = cur_col_q;
    end
    ch_col      = ({1'b0, base_col} >= cols_eff) ? last_col : base_col;
    ch_col_inc  = {1'b0, ch_col} + 1'b1;
    ch_wrap     = (ch_col_inc >= cols_eff);
    ch_next_row = ch_wrap ? 6'(base_row + 1'b1) : base_row;
    ch_next_col = ch_wrap ? '0 : ch_col_inc[ttcw_pkg::COL_W-1:0];
  end

  // sequencer
  always_comb begin
    ttcw_pkg::result_t res;
    logic              load;
    logic              start_scroll;

    res          = '0;
    load         = 1'b0;
    start_scroll = 1'b0;
    state_d      = state_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    cmd_d        = cmd_q;
    sweep_d      = sweep_q;
    scr_row_d    = scr_row_q;
    scr_col_d    = scr_col_q;
    wr_pend_d    = 1'b0;
    wr_addr_d    = wr_addr_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    mem_we       = wr_pend_q;
    mem_waddr    = wr_addr_q;
    mem_wdata    = rdata_q;
    mem_raddr    = cmd_i.rd_addr;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = ttcw_pkg::BLANK;
        sweep_d   = ttcw_pkg::ADDR_W'(sweep_q + 1'b1);
        if (&sweep_q) begin
          state_d = ST_IDLE;
          load    = (state_q == ST_CLEAR);
        end
      end

      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.kind)
            ttcw_pkg::CMD_CHAR: begin
              if (row_beyond) begin
                start_scroll = 1'b1;
              end else begin
                mem_we         = 1'b1;
                mem_waddr      = {cur_row_q[ttcw_pkg::ROW_W-1:0], ch_col};
                mem_wdata      = cmd_i.ch;
                cur_row_d      = ch_next_row;
                cur_col_d      = ch_next_col;
                res.wrote_char = 1'b1;
                res.cell_row   = cur_row_q[ttcw_pkg::ROW_W-1:0];
                res.cell_col   = ch_col;
                res.new_line   = ch_wrap;
                load           = 1'b1;
              end
            end
            ttcw_pkg::CMD_NEWLINE: begin
              if (row_beyond) begin
                start_scroll = 1'b1;
              end else begin
                cur_row_d    = 6'(cur_row_q + 1'b1);
                cur_col_d    = '0;
                res.new_line = 1'b1;
                load         = 1'b1;
              end
            end
            ttcw_pkg::CMD_CLEAR: begin
              cur_row_d = '0;
              cur_col_d = '0;
              state_d   = ST_CLEAR;
            end
            ttcw_pkg::CMD_HOME: begin
              cur_row_d = '0;
              cur_col_d = '0;
              load      = 1'b1;
            end
            ttcw_pkg::CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end

      // copy row r+1 to row r; the read is registered and its write goes out in the cycle after
      ST_SCROLL: begin
        mem_raddr = {ttcw_pkg::ROW_W'(scr_row_q + 1'b1), scr_col_q};
        wr_pend_d = 1'b1;
        wr_addr_d = {scr_row_q, scr_col_q};
        if (scr_col_q == last_col) begin
          scr_col_d = '0;
          if (scr_row_q == ttcw_pkg::ROW_W'(last_row - 1'b1)) begin
            state_d = ST_DRAIN;
          end else begin
            scr_row_d = ttcw_pkg::ROW_W'(scr_row_q + 1'b1);
          end
        end else begin
          scr_col_d = ttcw_pkg::COL_W'(scr_col_q + 1'b1);
        end
      end

      // last copy write goes out this cycle
      ST_DRAIN: begin
        scr_col_d = '0;
        state_d   = ST_BLANK;
      end

      // blank the bottom row
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {last_row, scr_col_q};
        mem_wdata = ttcw_pkg::BLANK;
        if (scr_col_q == last_col) begin
          state_d = ST_FINISH;
        end else begin
          scr_col_d = ttcw_pkg::COL_W'(scr_col_q + 1'b1);
        end
      end

      // complete the item that caused the scroll
      ST_FINISH: begin
        res.scrolled = 1'b1;
        res.new_line = 1'b1;
        if (cmd_q.kind == ttcw_pkg::CMD_CHAR) begin
          mem_we         = 1'b1;
          mem_waddr      = {last_row, ch_col};
          mem_wdata      = cmd_q.ch;
          cur_row_d      = ch_next_row;
          cur_col_d      = ch_next_col;
          res.wrote_char = 1'b1;
          res.cell_row   = last_row;
          res.cell_col   = ch_col;
          res.new_line   = ch_wrap;
        end else begin
          cur_row_d = rows_eff;
          cur_col_d = '0;
        end
        load    = 1'b1;
        state_d = ST_IDLE;
      end

      ST_READ: begin
        res.read_data = rdata_q;
        load          = 1'b1;
        state_d       = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_scroll) begin
      scr_row_d = '0;
      scr_col_d = '0;
      state_d   = (rows_eff == ttcw_pkg::ROWS_CFG_W'(1)) ? ST_BLANK : ST_SCROLL;
    end

    res.cursor_col = cur_col_d;
    res.cursor_row = cur_row_d;
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      cmd_q       <= '0;
      sweep_q     <= '0;
      scr_row_q   <= '0;
      scr_col_q   <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      cmd_q       <= cmd_d;
      sweep_q     <= sweep_d;
      scr_row_q   <= scr_row_d;
      scr_col_q   <= scr_col_d;
      wr_pend_q   <= wr_pend_d;
      wr_addr_q   <= wr_addr_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;
  assign init_done_o = (state_q != ST_INIT);

endmodule

`default_nettype wire

// File: sim/ttcw_checker.sv
// checker of the text terminal character writer: watches both streams and the apb port
// depends on ttcw_pkg; instantiated beside the block by text_terminal_char_writer_top_test
`default_nettype none

module ttcw_checker
  import ttcw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream, as seen at the block
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // char_code[7:0], read_row[12:8], read_col[18:13], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
  // result stream, as seen at the block
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // scrolled[0], wrote_char[1], cell_row[6:2], cell_col[12:7], new_line[13],
  // cursor_col[19:14], cursor_row[25:20], read_data[33:26], zero fill above
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration port
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [APB_ADDR_W-1:0]  paddr_i,
  input  logic [APB_DATA_W-1:0]  pwdata_i,
  input  logic [APB_DATA_W-1:0]  prdata_i,
  input  logic                   pready_i,
  // high once the stimulus is over and every result should have come
  input  logic                   drained_i,
  output int                     fails_o
);

  // shadow of the screen store, cursor and registers
  logic [7:0]            screen_mem [MAX_ROWS*MAX_COLS];
  int                    cur_col;
  int                    cur_line;
  logic [COLS_CFG_W-1:0] cfg_cols;
  logic [ROWS_CFG_W-1:0] cfg_rows;

  // results still owed by the block, oldest first
  result_t               pending_results [$];
  int                    fail_cnt = 0;
  int                    result_idx;
  bit                    drain_checked;

  assign fails_o = fail_cnt;

  task automatic report_mismatch(input string msg);
    if (fail_cnt < 100) $display("mismatch at %0t: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                result_idx, name, got, want));
  endtask

  // register values as the block uses them: 0 acts as 1, above the store size clips
  function automatic int geom_cols();
    if (cfg_cols == '0) return 1;
    if (cfg_cols > COLS_MAX) return MAX_COLS;
    return int'(cfg_cols);
  endfunction

  function automatic int geom_rows();
    if (cfg_rows == '0) return 1;
    if (cfg_rows > ROWS_MAX) return MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  // move the region up one row and blank its last row
  task automatic scroll_region(input int cols, input int rows);
    for (int r = 1; r < rows; r++)
      for (int c = 0; c < cols; c++)
        screen_mem[(r-1)*MAX_COLS + c] = screen_mem[r*MAX_COLS + c];
    for (int c = 0; c < cols; c++)
      screen_mem[(rows-1)*MAX_COLS + c] = BLANK;
  endtask

  // newline; from the pending row it scrolls and stays pending
  task automatic line_feed(input int cols, input int rows, output bit did_scroll);
    did_scroll = 1'b0;
    if (cur_line < rows) begin
      cur_line++;
    end else begin
      scroll_region(cols, rows);
      cur_line   = rows;
      did_scroll = 1'b1;
    end
    cur_col = 0;
  endtask

  // expected result of one input transaction, updating the shadow state
  task automatic predict_terminal(input logic [1:0] mode, input logic [7:0] ch,
                                  input logic [4:0] rrow, input logic [5:0] rcol,
                                  output result_t res);
    int cols;
    int rows;
    bit sc;
    cols = geom_cols();
    rows = geom_rows();
    res  = '0;
    case (mode)
      MODE_WRITE: begin
        if (ch == NEWLINE) begin
          line_feed(cols, rows, sc);
          res.scrolled = sc;
          res.new_line = 1'b1;
        end else if (ch >= FIRST_PRINTABLE) begin
          // scroll pending or cursor left below a shrunk region
          if (cur_line >= rows) begin
            scroll_region(cols, rows);
            res.scrolled = 1'b1;
            cur_line     = rows - 1;
            cur_col      = 0;
          end
          if (cur_col >= cols) cur_col = cols - 1;
          screen_mem[cur_line*MAX_COLS + cur_col] = ch;
          res.wrote_char = 1'b1;
          res.cell_row   = cur_line[ROW_W-1:0];
          res.cell_col   = cur_col[COL_W-1:0];
          cur_col++;
          // row end wraps as a newline
          if (cur_col >= cols) begin
            line_feed(cols, rows, sc);
            res.scrolled = res.scrolled | sc;
            res.new_line = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        foreach (screen_mem[i]) screen_mem[i] = BLANK;
        cur_col  = 0;
        cur_line = 0;
      end
      MODE_HOME: begin
        cur_col  = 0;
        cur_line = 0;
      end
      default: begin
        res.read_data = screen_mem[int'(rrow)*MAX_COLS + int'(rcol)];
      end
    endcase
    res.cursor_col = cur_col[5:0];
    res.cursor_row = cur_line[5:0];
  endtask

  // monitor of all three ports
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t want;
    result_t got;
    logic [APB_DATA_W-1:0] reg_val;
    if (!rst_ni) begin
      foreach (screen_mem[i]) screen_mem[i] = BLANK;
      cur_col       = 0;
      cur_line      = 0;
      cfg_cols      = COLS_RESET;
      cfg_rows      = ROWS_RESET;
      result_idx    = 0;
      drain_checked = 1'b0;
      pending_results.delete();
    end else begin
      // register transaction
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          if (paddr_i[2] == REG_ROWS) cfg_rows = pwdata_i[ROWS_CFG_W-1:0];
          else                        cfg_cols = pwdata_i[COLS_CFG_W-1:0];
        end else begin
          reg_val = (paddr_i[2] == REG_ROWS) ? APB_DATA_W'(cfg_rows) : APB_DATA_W'(cfg_cols);
          if (prdata_i !== reg_val)
            report_mismatch($sformatf("register read at %0d: got %0h, expected %0h",
                                      paddr_i, prdata_i, reg_val));
        end
      end
      // input transaction
      if (s_axis_tvalid && s_axis_tready) begin
        predict_terminal(s_axis_tuser[1:0], s_axis_tdata[7:0], s_axis_tdata[12:8],
                         s_axis_tdata[18:13], want);
        pending_results.push_back(want);
      end
      // result transaction
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[RES_W-1:0]);
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing outstanding", result_idx));
        end else begin
          want = pending_results.pop_front();
          compare_field("scrolled",   int'(got.scrolled),   int'(want.scrolled));
          compare_field("wrote_char", int'(got.wrote_char), int'(want.wrote_char));
          compare_field("cell_row",   int'(got.cell_row),   int'(want.cell_row));
          compare_field("cell_col",   int'(got.cell_col),   int'(want.cell_col));
          compare_field("new_line",   int'(got.new_line),   int'(want.new_line));
          compare_field("cursor_col", int'(got.cursor_col), int'(want.cursor_col));
          compare_field("cursor_row", int'(got.cursor_row), int'(want.cursor_row));
          compare_field("read_data",  int'(got.read_data),  int'(want.read_data));
        end
        result_idx++;
      end
      // anything still owed at the end
      if (drained_i && !drain_checked) begin
        drain_checked = 1'b1;
        if (pending_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/text_terminal_char_writer_top_test.sv
// stimulus and verdict for the text terminal character writer
// depends on ttcw_pkg, text_terminal_char_writer_top and ttcw_checker
`default_nettype none

module text_terminal_char_writer_top_test;
  import ttcw_pkg::*;

  // register byte addresses
  localparam logic [APB_ADDR_W-1:0] ADDR_COLS = 3'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_ROWS = 3'd4;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tready = 1'b0;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr         = '0;
  logic [APB_DATA_W-1:0]  pwdata        = '0;
  logic                   drained       = 1'b0;
  wire                    s_axis_tready;
  wire                    m_axis_tvalid;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;
  wire  [APB_DATA_W-1:0]  prdata;
  wire                    pready;
  int                     fail_total;

  int n_sent   = 0;
  int n_recv   = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int geo_cols = MAX_COLS;
  int geo_rows = MAX_ROWS;

  always #10 clk_i = ~clk_i;

  text_terminal_char_writer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ttcw_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .drained_i     (drained),
    .fails_o       (fail_total)
  );

  // one input transaction, after a random gap unless tx_quiet is set
  task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [4:0] rrow, input logic [5:0] rcol);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(0, 12));
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, rcol, rrow, ch};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // mostly text with newlines, some control bytes, reads, homes and clears
  task automatic send_random(input int nl_pct, input int hc_pct);
    int         pick;
    logic [1:0] mode;
    logic [7:0] ch;
    logic [4:0] rrow;
    logic [5:0] rcol;
    pick = int'($urandom_range(0, 99));
    ch   = 8'($urandom_range(0, 255));
    rrow = 5'($urandom_range(0, 31));
    rcol = 6'($urandom_range(0, 63));
    if (pick < hc_pct) begin
      mode = ($urandom_range(0, 2) == 0) ? MODE_CLEAR : MODE_HOME;
    end else if (pick < hc_pct + 8) begin
      mode = MODE_READ;
      if ($urandom_range(0, 1) == 1) begin
        rrow = 5'($urandom_range(0, geo_rows - 1));
        rcol = 6'($urandom_range(0, geo_cols - 1));
      end
    end else begin
      mode = MODE_WRITE;
      pick = int'($urandom_range(0, 99));
      if (pick < nl_pct)          ch = NEWLINE;
      else if (pick < nl_pct + 8) ch = 8'($urandom_range(0, 31));
      else                        ch = 8'($urandom_range(32, 255));
    end
    send_item(mode, ch, rrow, rcol);
  endtask

  // one apb transaction: setup cycle, then access cycle
  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (n_recv != n_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // new geometry while idle, then random text on it
  task automatic run_phase(input int cols, input int rows, input int items,
                           input int nl_pct, input int hc_pct);
    settle();
    apb_access(1'b1, ADDR_COLS, APB_DATA_W'(cols));
    apb_access(1'b1, ADDR_ROWS, APB_DATA_W'(rows));
    apb_access(1'b0, ADDR_COLS, '0);
    apb_access(1'b0, ADDR_ROWS, '0);
    geo_cols = (cols == 0) ? 1 : (cols > MAX_COLS) ? MAX_COLS : cols;
    geo_rows = (rows == 0) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    repeat (items) send_random(nl_pct, hc_pct);
  endtask

  // result side: random stalls before each transaction unless rx_quiet is set
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      stall = rx_quiet ? 0 : int'($urandom_range(0, 12));
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      n_recv++;
    end
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset contents, byte extremes, control bytes, every mode
    send_item(MODE_READ,  8'h00,   5'd0,  6'd0);
    send_item(MODE_READ,  8'hff,   5'd31, 6'd63);
    send_item(MODE_WRITE, 8'h41,   5'd0,  6'd0);
    send_item(MODE_WRITE, 8'hff,   5'd0,  6'd0);
    send_item(MODE_WRITE, 8'h80,   5'd0,  6'd0);
    send_item(MODE_WRITE, 8'h00,   5'd31, 6'd63);
    send_item(MODE_WRITE, 8'h1f,   5'd0,  6'd0);
    send_item(MODE_WRITE, 8'h09,   5'd0,  6'd0);
    send_item(MODE_WRITE, 8'h7f,   5'd0,  6'd0);
    send_item(MODE_WRITE, BLANK,   5'd0,  6'd0);
    send_item(MODE_WRITE, NEWLINE, 5'd0,  6'd0);
    send_item(MODE_WRITE, 8'h5a,   5'd0,  6'd0);
    send_item(MODE_READ,  8'h00,   5'd0,  6'd1);
    send_item(MODE_READ,  8'h00,   5'd1,  6'd0);
    send_item(MODE_HOME,  8'hff,   5'd31, 6'd63);
    send_item(MODE_WRITE, 8'h61,   5'd0,  6'd0);
    send_item(MODE_READ,  8'h00,   5'd0,  6'd0);
    send_item(MODE_CLEAR, 8'h55,   5'd10, 6'd20);
    send_item(MODE_READ,  8'h00,   5'd0,  6'd1);
    send_item(MODE_WRITE, NEWLINE, 5'd0,  6'd0);
    send_item(MODE_WRITE, NEWLINE, 5'd0,  6'd0);

    // random text on the reset geometry, no homes so the bottom is reached
    tx_quiet = 1'b0;
    repeat (100) send_random(40, 0);

    // a run of geometries, extremes and out-of-range values among them
    run_phase(8,   4,  150, 15, 6);
    run_phase(1,   1,  60,  10, 4);
    run_phase(0,   0,  60,  10, 4);
    run_phase(64,  1,  60,  10, 2);
    run_phase(1,   32, 60,  10, 2);
    run_phase(127, 63, 100, 40, 0);
    run_phase(5,   3,  120, 15, 6);
    run_phase(20,  8,  120, 20, 4);
    run_phase(3,   2,  100, 15, 6);
    run_phase(12,  5,  120, 20, 6);
    run_phase(int'($urandom_range(0, 127)), int'($urandom_range(0, 63)), 60, 30, 2);
    run_phase(int'($urandom_range(0, 127)), int'($urandom_range(0, 63)), 60, 30, 2);

    settle();
    drained <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: text_terminal_char_writer_top.f
+incdir+design
design/ttcw_pkg.sv
design/ttcw_front.sv
design/ttcw_queue.sv
design/ttcw_back.sv
design/text_terminal_char_writer_top.sv
sim/ttcw_checker.sv
sim/text_terminal_char_writer_top_test.sv
